/* rtl/ray_box_slab_hit_test_assert.svh */
// Assertion macros used by the checker of the ray/box hit test.
`ifndef RAY_BOX_SLAB_HIT_TEST_ASSERT_SVH
`define RAY_BOX_SLAB_HIT_TEST_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RBS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rbs_pkg.sv */
package rbs_pkg;

  localparam int NUM_AXES    = 3;
  localparam int CELL_STAGES = 2;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] dist_t;

  // Operands of all axes; the cell works on index 0 and rotates the rest down.
  typedef struct packed {
    fix_t [NUM_AXES-1:0] org;
    fix_t [NUM_AXES-1:0] inv;
    fix_t [NUM_AXES-1:0] bmin;
    fix_t [NUM_AXES-1:0] bmax;
  } ray_t;

  typedef struct packed {
    ray_t  ray;
    dist_t tlo;
    dist_t thi;
    logic  hit;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } link_t;

  localparam dist_t DIST_MIN = {1'b1, {63{1'b0}}};
  localparam dist_t DIST_MAX = {1'b0, {63{1'b1}}};

endpackage

/* rtl/rbs_cell.sv */
module rbs_cell (
  input  logic          clk,
  input  logic          rst,
  input  rbs_pkg::link_t up,
  output logic          up_stall,
  output rbs_pkg::link_t down,
  input  logic          down_stall
);

  logic                 s1_valid;
  rbs_pkg::word_t       s1_word;
  rbs_pkg::dist_t       s1_a;
  rbs_pkg::dist_t       s1_b;
  logic                 s2_valid;
  rbs_pkg::word_t       s2_word;

  logic                 ld1;
  logic                 ld2;
  logic signed [32:0]   dmin;
  logic signed [32:0]   dmax;
  logic signed [64:0]   prod_a;
  logic signed [64:0]   prod_b;
  rbs_pkg::dist_t       lo;
  rbs_pkg::dist_t       hi;
  logic                 miss;
  rbs_pkg::word_t       s2_word_next;

  assign ld2      = !s2_valid || !down_stall;
  assign ld1      = !s1_valid || ld2;
  assign up_stall = !ld1;

  // Slab distances for the axis at index 0, exact in 64 bits.
  assign dmin   = 33'($signed(up.word.ray.bmin[0])) - 33'($signed(up.word.ray.org[0]));
  assign dmax   = 33'($signed(up.word.ray.bmax[0])) - 33'($signed(up.word.ray.org[0]));
  assign prod_a = dmin * $signed(up.word.ray.inv[0]);
  assign prod_b = dmax * $signed(up.word.ray.inv[0]);

  always_comb begin
    if ($signed(s1_a) > $signed(s1_b)) begin
      lo = s1_b;
      hi = s1_a;
    end else begin
      lo = s1_a;
      hi = s1_b;
    end
    miss = ($signed(s1_word.tlo) > $signed(hi)) || ($signed(lo) > $signed(s1_word.thi));

    s2_word_next = s1_word;
    s2_word_next.hit = s1_word.hit && !miss;
    s2_word_next.tlo = ($signed(lo) > $signed(s1_word.tlo)) ? lo : s1_word.tlo;
    s2_word_next.thi = ($signed(hi) < $signed(s1_word.thi)) ? hi : s1_word.thi;
    // rotate so the next axis lands at index 0
    s2_word_next.ray.org  = {s1_word.ray.org[0],  s1_word.ray.org[2:1]};
    s2_word_next.ray.inv  = {s1_word.ray.inv[0],  s1_word.ray.inv[2:1]};
    s2_word_next.ray.bmin = {s1_word.ray.bmin[0], s1_word.ray.bmin[2:1]};
    s2_word_next.ray.bmax = {s1_word.ray.bmax[0], s1_word.ray.bmax[2:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ld1) s1_valid <= up.valid;
      if (ld2) s2_valid <= s1_valid;
    end
    if (ld1) begin
      s1_word <= up.word;
      s1_a    <= prod_a[63:0];
      s1_b    <= prod_b[63:0];
    end
    if (ld2) begin
      s2_word <= s2_word_next;
    end
  end

  assign down.valid = s2_valid;
  assign down.word  = s2_word;

endmodule

/* rtl/ray_box_slab_hit_test.sv */
// Ray / axis-aligned box hit test by the slab method. Each word carries a ray
// (origin and per-axis inverse direction) and a box (lower and upper corners),
// all signed Q16.16, and yields one hit bit; touching intervals count as a hit
// and boxes behind the origin are not rejected. A new word is taken every
// cycle unless a stall reaches the input. There are three identical axis
// cells, x then y then z, each with a multiply stage (two 33x32 products)
// and an order-and-narrow stage. The last stage is the output register, so
// a finished result that waits stalls the input only once the stages are full.
module ray_box_slab_hit_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [31:0] inv_dir_x,
  input  logic [31:0] inv_dir_y,
  input  logic [31:0] inv_dir_z,
  input  logic [31:0] box_min_x,
  input  logic [31:0] box_min_y,
  input  logic [31:0] box_min_z,
  input  logic [31:0] box_max_x,
  input  logic [31:0] box_max_y,
  input  logic [31:0] box_max_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit
);

  rbs_pkg::link_t                   link  [rbs_pkg::NUM_AXES+1];
  logic [rbs_pkg::NUM_AXES:0]       stall;

  always_comb begin
    link[0].valid          = in_valid;
    link[0].word.ray.org   = {origin_z,  origin_y,  origin_x};
    link[0].word.ray.inv   = {inv_dir_z, inv_dir_y, inv_dir_x};
    link[0].word.ray.bmin  = {box_min_z, box_min_y, box_min_x};
    link[0].word.ray.bmax  = {box_max_z, box_max_y, box_max_x};
    // open interval: the first axis narrows it to its own slab
    link[0].word.tlo       = rbs_pkg::DIST_MIN;
    link[0].word.thi       = rbs_pkg::DIST_MAX;
    link[0].word.hit       = 1'b1;
  end

  for (genvar i = 0; i < rbs_pkg::NUM_AXES; i++) begin : g_cell
    rbs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up         (link[i]),
      .up_stall   (stall[i]),
      .down       (link[i+1]),
      .down_stall (stall[i+1])
    );
  end

  assign in_stall                  = stall[0];
  assign stall[rbs_pkg::NUM_AXES]  = out_stall;
  assign out_valid                 = link[rbs_pkg::NUM_AXES].valid;
  assign hit                       = link[rbs_pkg::NUM_AXES].word.hit;

endmodule

/* rtl/rbs_checker.sv */
`include "ray_box_slab_hit_test_assert.svh"

module rbs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit
);

  localparam int DEPTH = rbs_pkg::NUM_AXES * rbs_pkg::CELL_STAGES;
  localparam int CW    = $clog2(DEPTH + 2);

  logic [CW-1:0] inflight;
  logic [CW-1:0] inflight_next;
  logic          acc_in;
  logic          acc_out;

  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;

  always_comb begin
    inflight_next = inflight + CW'(acc_in) - CW'(acc_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `RBS_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid, "result valid right after reset")
  `RBS_ASSERT_NOW(a_no_invented, out_valid, inflight != '0, "result with no word in flight")
  `RBS_ASSERT_NOW(a_depth, 1'b1, inflight <= CW'(DEPTH), "more words in flight than stages")
  `RBS_ASSERT_NEXT(a_hold_hit, out_valid && out_stall, out_valid && $stable(hit), "stalled result changed")

endmodule

bind ray_box_slab_hit_test rbs_checker u_rbs_checker (.*);
